FILE: rtl/core/json_string_unescape_utf8_unit_macros.svh
// Assertion helpers used by jsu_back.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/jsu_pkg.sv
package jsu_pkg;

	typedef enum logic [3:0] {
		ST_DATA    = 4'd0,
		ST_END     = 4'd1,
		ST_NOQUOTE = 4'd2,
		ST_CONTROL = 4'd3,
		ST_BADESC  = 4'd4,
		ST_BADHEX  = 4'd5,
		ST_BADPAIR = 4'd6,
		ST_LONELOW = 4'd7,
		ST_TRUNC   = 4'd8
	} jsu_status_t;

	// one decoded input: 1 to 4 result words
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		jsu_status_t     status;
	} jsu_job_t;

endpackage

FILE: rtl/core/jsu_front.sv
module jsu_front
	import jsu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_kind,
	input  logic [7:0] in_byte,
	input  logic     q_full,
	output logic     in_ready,
	output logic     push,
	output jsu_job_t push_job
);

	typedef enum logic [2:0] {
		M_IDLE, M_STR, M_ESC, M_HEX1, M_WANT_BS, M_WANT_U, M_HEX2
	} mode_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_U     = 8'h75;

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] quad_q, quad_d;
	logic [9:0]  hi_q, hi_d;

	logic        accept;
	logic        hex_ok;
	logic [3:0]  hex_v;
	logic [15:0] quad_nx;
	logic [20:0] pair_cp;
	jsu_job_t    enc_quad, enc_pair;

	function automatic jsu_job_t utf8_enc(input logic [20:0] cp);
		jsu_job_t j;
		j = '0;
		j.status = ST_DATA;
		if (cp <= 21'h7f) begin
			j.bytes[0] = cp[7:0];
			j.last_idx = 2'd0;
		end else if (cp <= 21'h7ff) begin
			j.bytes[0] = {3'b110, cp[10:6]};
			j.bytes[1] = {2'b10, cp[5:0]};
			j.last_idx = 2'd1;
		end else if (cp <= 21'hffff) begin
			j.bytes[0] = {4'b1110, cp[15:12]};
			j.bytes[1] = {2'b10, cp[11:6]};
			j.bytes[2] = {2'b10, cp[5:0]};
			j.last_idx = 2'd2;
		end else begin
			j.bytes[0] = {5'b11110, cp[20:18]};
			j.bytes[1] = {2'b10, cp[17:12]};
			j.bytes[2] = {2'b10, cp[11:6]};
			j.bytes[3] = {2'b10, cp[5:0]};
			j.last_idx = 2'd3;
		end
		return j;
	endfunction

	function automatic jsu_job_t one_word(input logic [7:0] b, input jsu_status_t st);
		jsu_job_t j;
		j = '0;
		j.bytes[0] = b;
		j.status   = st;
		return j;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39)
			hex_v = in_byte[3:0];
		else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46))
			hex_v = in_byte[3:0] + 4'd9;
		else
			hex_ok = 1'b0;
	end

	assign quad_nx  = {quad_q[11:0], hex_v};
	assign pair_cp  = {(11'(hi_q) + 11'd64), quad_nx[9:0]};
	assign enc_quad = utf8_enc({5'd0, quad_nx});
	assign enc_pair = utf8_enc(pair_cp);

	always_comb begin
		mode_d    = mode_q;
		hex_cnt_d = hex_cnt_q;
		quad_d    = quad_q;
		hi_d      = hi_q;
		push      = 1'b0;
		push_job  = '0;
		if (accept) begin
			if (in_kind) begin
				push      = 1'b1;
				push_job  = one_word(8'h00, ST_TRUNC);
				mode_d    = M_IDLE;
				hex_cnt_d = 2'd0;
			end else begin
				case (mode_q)
					M_STR: begin
						if (in_byte == CH_QUOTE) begin
							push     = 1'b1;
							push_job = one_word(8'h00, ST_END);
							mode_d   = M_IDLE;
						end else if (in_byte < 8'h20) begin
							push     = 1'b1;
							push_job = one_word(8'h00, ST_CONTROL);
							mode_d   = M_IDLE;
						end else if (in_byte == CH_BSL) begin
							mode_d = M_ESC;
						end else begin
							push     = 1'b1;
							push_job = one_word(in_byte, ST_DATA);
						end
					end
					M_ESC: begin
						push   = 1'b1;
						mode_d = M_STR;
						case (in_byte)
							8'h22: push_job = one_word(8'h22, ST_DATA);
							8'h5c: push_job = one_word(8'h5c, ST_DATA);
							8'h2f: push_job = one_word(8'h2f, ST_DATA);
							8'h62: push_job = one_word(8'h08, ST_DATA);
							8'h66: push_job = one_word(8'h0c, ST_DATA);
							8'h6e: push_job = one_word(8'h0a, ST_DATA);
							8'h72: push_job = one_word(8'h0d, ST_DATA);
							8'h74: push_job = one_word(8'h09, ST_DATA);
							8'h75: begin
								push      = 1'b0;
								mode_d    = M_HEX1;
								hex_cnt_d = 2'd0;
								quad_d    = 16'd0;
							end
							default: begin
								push_job  = one_word(8'h00, ST_BADESC);
								mode_d    = M_IDLE;
								hex_cnt_d = 2'd0;
							end
						endcase
					end
					M_HEX1, M_HEX2: begin
						if (!hex_ok) begin
							push      = 1'b1;
							push_job  = one_word(8'h00, ST_BADHEX);
							mode_d    = M_IDLE;
							hex_cnt_d = 2'd0;
						end else begin
							quad_d = quad_nx;
							if (hex_cnt_q != 2'd3) begin
								hex_cnt_d = hex_cnt_q + 2'd1;
							end else begin
								hex_cnt_d = 2'd0;
								if (mode_q == M_HEX1) begin
									if (quad_nx[15:10] == 6'b110110) begin
										hi_d   = quad_nx[9:0];
										mode_d = M_WANT_BS;
									end else if (quad_nx[15:10] == 6'b110111) begin
										push     = 1'b1;
										push_job = one_word(8'h00, ST_LONELOW);
										mode_d   = M_IDLE;
									end else begin
										push     = 1'b1;
										push_job = enc_quad;
										mode_d   = M_STR;
									end
								end else begin
									push = 1'b1;
									if (quad_nx[15:10] == 6'b110111) begin
										push_job = enc_pair;
										mode_d   = M_STR;
									end else begin
										push_job = one_word(8'h00, ST_BADPAIR);
										mode_d   = M_IDLE;
									end
								end
							end
						end
					end
					M_WANT_BS: begin
						if (in_byte == CH_BSL) begin
							mode_d = M_WANT_U;
						end else begin
							push      = 1'b1;
							push_job  = one_word(8'h00, ST_BADPAIR);
							mode_d    = M_IDLE;
							hex_cnt_d = 2'd0;
						end
					end
					M_WANT_U: begin
						if (in_byte == CH_U) begin
							mode_d    = M_HEX2;
							hex_cnt_d = 2'd0;
							quad_d    = 16'd0;
						end else begin
							push      = 1'b1;
							push_job  = one_word(8'h00, ST_BADPAIR);
							mode_d    = M_IDLE;
							hex_cnt_d = 2'd0;
						end
					end
					default: begin
						if (in_byte == CH_QUOTE) begin
							mode_d    = M_STR;
							hex_cnt_d = 2'd0;
						end else begin
							push      = 1'b1;
							push_job  = one_word(8'h00, ST_NOQUOTE);
							mode_d    = M_IDLE;
							hex_cnt_d = 2'd0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			hex_cnt_q <= 2'd0;
			quad_q    <= 16'd0;
			hi_q      <= 10'd0;
		end else begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			quad_q    <= quad_d;
			hi_q      <= hi_d;
		end
	end

endmodule

FILE: rtl/core/jsu_queue.sv
module jsu_queue
	import jsu_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  jsu_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output jsu_job_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	jsu_job_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

FILE: rtl/core/jsu_back.sv
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_back
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  jsu_job_t    head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output jsu_status_t out_status,
	output logic        out_last
);

	logic        valid_q;
	logic [1:0]  idx_q;
	logic [7:0]  byte_q;
	jsu_status_t status_q;
	logic        last_q;
	logic        adv;
	logic        load;
	logic        at_end;

	assign adv    = !valid_q || out_ready;
	assign load   = head_valid && adv;
	assign at_end = (idx_q == head.last_idx);
	assign pop    = load && at_end;

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign out_status = status_q;
	assign out_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (adv)
				valid_q <= head_valid;
			if (load)
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= head.bytes[idx_q];
			status_q <= head.status;
			last_q   <= at_end;
		end
	end

	// error and end words are single and always close their input
	`JSU_ASSERT_IMP(a_status_last, valid_q && status_q != ST_DATA, last_q && byte_q == 8'h00, "non-data word without tlast")
	`JSU_ASSERT_IMP(a_idx_range, head_valid, idx_q <= head.last_idx, "word index past end of entry")
	`JSU_ASSERT_NEXT(a_mid_entry, load && !at_end, idx_q != 2'd0 && head_valid, "entry left early")

endmodule

FILE: rtl/core/json_string_unescape_utf8_unit.sv
// Channel | Dir | tdata                            | tuser      | tlast
// s_*     | in  | [7:0] data_byte                  | [0] kind   | -
// m_*     | out | [7:0] out_byte, [11:8] status    | -          | last
//
// One input word per cycle is taken while the job queue has room.
// Each input yields 0 to 4 output words; the back end sends one word per cycle
// while m_tready is high, so a \u escape that encodes to n bytes holds the
// queue head until all n bytes are sent. Queue depth QUEUE_DEPTH jobs.
// Reset (arst_n low) returns the decoder to idle and empties the queue.
// Output stalls fill the queue; input stalls only drain it.

module json_string_unescape_utf8_unit
	import jsu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] status, [15:12] zero
	output logic        m_tlast
);

	logic        push, pop, q_full, head_valid;
	jsu_job_t    push_job, head;
	logic [7:0]  out_byte;
	jsu_status_t out_status;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push),
		.push_job (push_job)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (out_byte),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tdata = {4'd0, out_status, out_byte};

endmodule
